### hdl/itoa_pkg.sv
// Shared types and constants of the integer to ASCII formatter.
package itoa_pkg;

  // One request: a value and its conversion options.
  typedef struct packed {
    logic [63:0] value;
    logic        radix_hex;
    logic        signed_mode;
    logic        upper_case;
    logic [5:0]  field_width;
    logic        zero_fill;
    logic        left_justify;
    logic        alternate_prefix;
  } itoa_req_t;

  // One result: a single character of the field.
  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } itoa_res_t;

  // Character source chosen by the controller for an emitted character.
  typedef enum logic [2:0] {
    SEL_SPACE = 3'd0,
    SEL_ZERO  = 3'd1,
    SEL_MINUS = 3'd2,
    SEL_X     = 3'd3,
    SEL_DIGIT = 3'd4
  } itoa_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      shift_digit;
    logic      cnt_load_pad;
    logic      cnt_dec;
    logic      emit;
    logic      last;
    itoa_sel_t sel;
  } itoa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hex;
    logic neg;
    logic alt;
    logic zpad;
    logic rpad;
    logic cnt_zero;
    logic cnt_one;
    logic digit_one;
    logic top_found;
    logic pad_calc_nz;
  } itoa_sts_t;

  // ASCII codes.
  localparam logic [6:0] ASC_SPACE   = 7'h20;
  localparam logic [6:0] ASC_MINUS   = 7'h2D;
  localparam logic [6:0] ASC_ZERO    = 7'h30;
  localparam logic [6:0] ASC_UPPER_A = 7'h41;
  localparam logic [6:0] ASC_LOWER_A = 7'h61;
  localparam logic [6:0] ASC_UPPER_X = 7'h58;
  localparam logic [6:0] ASC_LOWER_X = 7'h78;

  // Digit counts loaded into the digit count register, and the conversion bit count less one.
  localparam logic [4:0] DEC_DIGITS = 5'd20;
  localparam logic [4:0] HEX_DIGITS = 5'd16;
  localparam logic [5:0] CONV_BITS_M1 = 6'd63;

endpackage

### hdl/itoa_datapath.sv
// Datapath: option registers, binary to BCD converter, digit register and counters.
module itoa_datapath
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  itoa_req_t request,
  input  itoa_cmd_t cmd,
  output itoa_sts_t sts,
  output itoa_res_t result,
  output logic      strobe
);

  itoa_req_t   opts;
  logic        neg;
  logic [63:0] mag;
  logic [79:0] dig;
  logic [79:0] dig_adj;
  logic [4:0]  ndig;
  logic [5:0]  cnt;
  logic        load_neg;
  logic [5:0]  body;
  logic [5:0]  pad_calc;
  logic [1:0]  npre;
  logic [3:0]  top;
  logic [6:0]  ch;

  // A negative signed decimal value is printed by its magnitude.
  assign load_neg = request.signed_mode & ~request.radix_hex & request.value[63];

  // Add three to each BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < 20; i++) begin
      dig_adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3 : dig[i*4 +: 4];
    end
  end

  // Field length arithmetic for the padding count.
  always_comb begin
    npre = opts.alternate_prefix ? (opts.radix_hex ? 2'd2 : 2'd1) : 2'd0;
    body = {5'd0, neg} + {4'd0, npre} + {1'b0, ndig};
    pad_calc = (opts.field_width > body) ? opts.field_width - body : 6'd0;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opts <= request;
      neg  <= load_neg;
      mag  <= load_neg ? 64'd0 - request.value : request.value;
      dig  <= request.radix_hex ? {request.value, 16'd0} : 80'd0;
      ndig <= request.radix_hex ? HEX_DIGITS : DEC_DIGITS;
    end else if (cmd.conv_step) begin
      dig <= {dig_adj[78:0], mag[63]};
      mag <= {mag[62:0], 1'b0};
    end else if (cmd.shift_digit) begin
      dig  <= {dig[75:0], 4'd0};
      ndig <= ndig - 5'd1;
    end
    if (cmd.load) begin
      cnt <= CONV_BITS_M1;
    end else if (cmd.cnt_load_pad) begin
      cnt <= pad_calc;
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 6'd1;
    end
  end

  // Status for the controller.
  assign top = dig[79:76];
  always_comb begin
    sts.hex         = opts.radix_hex;
    sts.neg         = neg;
    sts.alt         = opts.alternate_prefix;
    sts.zpad        = opts.zero_fill;
    sts.rpad        = opts.left_justify;
    sts.cnt_zero    = (cnt == 6'd0);
    sts.cnt_one     = (cnt == 6'd1);
    sts.digit_one   = (ndig == 5'd1);
    sts.top_found   = (ndig == 5'd1) || (top != 4'd0);
    sts.pad_calc_nz = (pad_calc != 6'd0);
  end

  // Character selection.
  always_comb begin
    case (cmd.sel)
      SEL_SPACE: ch = ASC_SPACE;
      SEL_ZERO:  ch = ASC_ZERO;
      SEL_MINUS: ch = ASC_MINUS;
      SEL_X:     ch = opts.upper_case ? ASC_UPPER_X : ASC_LOWER_X;
      SEL_DIGIT: begin
        if (top < 4'd10) begin
          ch = ASC_ZERO + {3'd0, top};
        end else begin
          ch = (opts.upper_case ? ASC_UPPER_A : ASC_LOWER_A) + {3'd0, top} - 7'd10;
        end
      end
      default:   ch = ASC_SPACE;
    endcase
  end

  // Registered result and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      result.character <= ch;
      result.last      <= cmd.last;
    end
  end

endmodule

### hdl/itoa_ctrl.sv
// Controller: sequences conversion, leading zero scan and character output.
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_CONV = 10'b0000000010,
    ST_SCAN = 10'b0000000100,
    ST_LPAD = 10'b0000001000,
    ST_SIGN = 10'b0000010000,
    ST_PRE0 = 10'b0000100000,
    ST_PREX = 10'b0001000000,
    ST_ZPAD = 10'b0010000000,
    ST_DIGS = 10'b0100000000,
    ST_RPAD = 10'b1000000000
  } state_t;

  state_t state, state_next;
  state_t aft_scan, aft_sign, aft_pre0, aft_prex, aft_digs;
  logic   en_rpad;

  // Order of the field segments, skipping those that are empty.
  always_comb begin
    en_rpad  = sts.rpad & ~sts.cnt_zero;
    aft_digs = en_rpad ? ST_RPAD : ST_IDLE;
    aft_prex = (~sts.rpad & sts.zpad & sts.pad_calc_nz) ? ST_ZPAD : ST_DIGS;
    aft_pre0 = (sts.alt & sts.hex) ? ST_PREX : aft_prex;
    aft_sign = sts.alt ? ST_PRE0 : aft_pre0;
    aft_scan = (~sts.rpad & ~sts.zpad & sts.pad_calc_nz) ? ST_LPAD
             : (sts.neg ? ST_SIGN : aft_sign);
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sel = SEL_SPACE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.hex) begin
          state_next = ST_SCAN;
        end else begin
          cmd.conv_step = 1'b1;
          cmd.cnt_dec   = 1'b1;
          if (sts.cnt_zero) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.top_found) begin
          cmd.cnt_load_pad = 1'b1;
          state_next       = aft_scan;
        end else begin
          cmd.shift_digit = 1'b1;
        end
      end
      ST_LPAD: begin
        cmd.emit    = 1'b1;
        cmd.sel     = SEL_SPACE;
        cmd.cnt_dec = 1'b1;
        if (sts.cnt_one) begin
          state_next = sts.neg ? ST_SIGN : aft_sign;
        end
      end
      ST_SIGN: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_MINUS;
        state_next = aft_sign;
      end
      ST_PRE0: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_ZERO;
        state_next = aft_pre0;
      end
      ST_PREX: begin
        cmd.emit   = 1'b1;
        cmd.sel    = SEL_X;
        state_next = aft_prex;
      end
      ST_ZPAD: begin
        cmd.emit    = 1'b1;
        cmd.sel     = SEL_ZERO;
        cmd.cnt_dec = 1'b1;
        if (sts.cnt_one) begin
          state_next = ST_DIGS;
        end
      end
      ST_DIGS: begin
        cmd.emit        = 1'b1;
        cmd.sel         = SEL_DIGIT;
        cmd.shift_digit = 1'b1;
        if (sts.digit_one) begin
          cmd.last   = ~en_rpad;
          state_next = aft_digs;
        end
      end
      ST_RPAD: begin
        cmd.emit    = 1'b1;
        cmd.sel     = SEL_SPACE;
        cmd.cnt_dec = 1'b1;
        if (sts.cnt_one) begin
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### hdl/integer_to_ascii_formatter.sv
// Top level of the printf-style integer to ASCII formatter.
// Sequence: after a request is accepted, a decimal value goes through BCD conversion and
// then a leading zero scan before the first character is strobed; hex skips the conversion.
// Throughput: one character per cycle; the next request is accepted only once the previous
// field is complete, so the gap between requests is set by the digit scan and field length.
// Results cannot be stalled; synchronous reset returns the controller to idle, clears strobe.
module integer_to_ascii_formatter
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  itoa_req_t request,
  output itoa_res_t result,
  output logic      strobe
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  // Sequencing.
  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Conversion and character generation.
  itoa_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .strobe  (strobe)
  );

endmodule
